[sv/wtsc_pkg.sv]
// ----------------------------------------------------------------------------
// Window threshold stepper controller package
// Shared types, constants and the coil phase table of the window controller.
// ----------------------------------------------------------------------------
`default_nettype none

package wtsc_pkg;

	localparam int CYCLES_PER_MOVE = 20;
	localparam int TotalSteps      = 8 * CYCLES_PER_MOVE;
	localparam int StepW           = $clog2(TotalSteps);

	localparam logic [6:0] SmokeMul  = 7'd99;
	localparam logic [6:0] LimMax    = 7'd99;
	localparam logic [7:0] LightMax  = 8'd255;

	localparam logic [6:0] SmokeLimitRst    = 7'd50;
	localparam logic [7:0] LightLimitRst    = 8'd50;
	localparam logic [6:0] TempLimitRst     = 7'd25;
	localparam logic [6:0] HumidityLimitRst = 7'd70;

	typedef enum logic [4:0] {
		KEY_NONE      = 5'd0,
		KEY_EDIT_ON   = 5'd1,
		KEY_EDIT_OFF  = 5'd2,
		KEY_TEMP_UP   = 5'd3,
		KEY_TEMP_DN   = 5'd4,
		KEY_SMOKE_UP  = 5'd5,
		KEY_SMOKE_DN  = 5'd6,
		KEY_HUMID_UP  = 5'd7,
		KEY_HUMID_DN  = 5'd8,
		KEY_LIGHT_UP  = 5'd9,
		KEY_LIGHT_DN  = 5'd10
	} key_t;

	typedef enum logic [1:0] {
		START_NONE    = 2'd0,
		START_FORWARD = 2'd1,
		START_REVERSE = 2'd2
	} start_t;

	localparam logic FUNC_CONTROL = 1'b0;
	localparam logic FUNC_TICK    = 1'b1;

	typedef struct packed {
		logic       func;
		logic [4:0] key_code;
		logic [7:0] smoke_raw;
		logic [7:0] light_raw;
		logic [7:0] temperature;
		logic [6:0] humidity;
		logic       manual_pressed;
	} wtsc_cmd_t;

	typedef struct packed {
		logic [3:0] coils;
		logic       busy_res;
		logic       position_flag;
		logic       edit_mode;
		logic [7:0] smoke_scaled;
		logic [1:0] move_started;
		logic [6:0] limit_smoke;
		logic [7:0] limit_light;
		logic [6:0] limit_temp;
		logic [6:0] limit_humidity;
	} wtsc_res_t;

	// Coil line touched in each phase; direction 0 is forward, 1 is reverse.
	function automatic logic [1:0] coil_bit(input logic dir, input logic [2:0] ph);
		logic [1:0] b;
		b = 2'd0;
		if (!dir) begin
			unique case (ph)
				3'd0: b = 2'd2;
				3'd1: b = 2'd3;
				3'd2: b = 2'd1;
				3'd3: b = 2'd2;
				3'd4: b = 2'd0;
				3'd5: b = 2'd1;
				3'd6: b = 2'd3;
				3'd7: b = 2'd0;
				default: b = 2'd0;
			endcase
		end else begin
			unique case (ph)
				3'd0: b = 2'd0;
				3'd1: b = 2'd3;
				3'd2: b = 2'd1;
				3'd3: b = 2'd0;
				3'd4: b = 2'd2;
				3'd5: b = 2'd1;
				3'd6: b = 2'd3;
				3'd7: b = 2'd2;
				default: b = 2'd0;
			endcase
		end
		return b;
	endfunction

endpackage

`default_nettype wire

[sv/window_threshold_stepper_controller_core.sv]
// ----------------------------------------------------------------------------
// Window threshold stepper controller core
// Keypad limit editing, smoke/temperature/humidity alarms, a light trigger and a
// four-coil stepper sequencer, one beat in and one result beat out.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-----------------------
//  cmd     | in        | cmd_valid/cmd_ready  | wtsc_pkg::wtsc_cmd_t
//  res     | out       | res_valid/res_ready  | wtsc_pkg::wtsc_res_t
//
// A beat is captured in an input register and evaluated against the controller
// state once the output register is free; its result beat is registered there.
// One beat is accepted per cycle; a stalled res channel backs up through the
// two registers before cmd_ready drops. Reset puts the limits to their
// defaults, the coils to all ones and the position flag to one.
`default_nettype none

module window_threshold_stepper_controller_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cmd_valid,
	output logic                  cmd_ready,
	input  wtsc_pkg::wtsc_cmd_t   cmd,
	output logic                  res_valid,
	input  wire                   res_ready,
	output wtsc_pkg::wtsc_res_t   res
);

	logic                 valid_s1;
	wtsc_pkg::wtsc_cmd_t  cmd_s1;
	logic                 adv;
	logic                 out_load;

	logic                 edit_q;
	logic                 pos_q;
	logic [6:0]           smoke_lim_q;
	logic [7:0]           light_lim_q;
	logic [6:0]           temp_lim_q;
	logic [6:0]           humid_lim_q;
	logic [3:0]           coils_q;
	logic                 moving_q;
	logic                 dir_q;
	logic [wtsc_pkg::StepW-1:0] step_q;

	logic                 edit_d;
	logic                 pos_d;
	logic [6:0]           smoke_lim_d;
	logic [7:0]           light_lim_d;
	logic [6:0]           temp_lim_d;
	logic [6:0]           humid_lim_d;
	logic [3:0]           coils_d;
	logic                 moving_d;
	logic                 dir_d;
	logic [wtsc_pkg::StepW-1:0] step_d;
	logic [7:0]           scaled;
	logic [14:0]          product;
	logic [1:0]           started;
	logic                 alarm;
	logic                 bright;
	logic [3:0]           mask;
	logic                 last_step;

	assign out_load  = !res_valid || res_ready;
	assign adv       = valid_s1 && out_load;
	assign cmd_ready = !valid_s1 || out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	assign product   = cmd_s1.smoke_raw * wtsc_pkg::SmokeMul;
	assign alarm     = ({1'b0, product[14:7]} > {2'b00, smoke_lim_q})
		|| (cmd_s1.temperature > {1'b0, temp_lim_q})
		|| (cmd_s1.humidity > humid_lim_q);
	assign bright    = (cmd_s1.light_raw > light_lim_q) || cmd_s1.manual_pressed;
	assign mask      = 4'b0001 << wtsc_pkg::coil_bit(dir_q, step_q[2:0]);
	assign last_step = step_q == wtsc_pkg::StepW'(wtsc_pkg::TotalSteps - 1);

	always_comb begin
		edit_d      = edit_q;
		pos_d       = pos_q;
		smoke_lim_d = smoke_lim_q;
		light_lim_d = light_lim_q;
		temp_lim_d  = temp_lim_q;
		humid_lim_d = humid_lim_q;
		coils_d     = coils_q;
		moving_d    = moving_q;
		dir_d       = dir_q;
		step_d      = step_q;
		scaled      = 8'd0;
		started     = wtsc_pkg::START_NONE;
		if (cmd_s1.func == wtsc_pkg::FUNC_CONTROL) begin
			scaled = product[14:7];
			if (!moving_q) begin
				if (cmd_s1.key_code == wtsc_pkg::KEY_EDIT_ON) begin
					edit_d = 1'b1;
				end else if (cmd_s1.key_code == wtsc_pkg::KEY_EDIT_OFF) begin
					edit_d = 1'b0;
				end
				if (alarm) begin
					if (pos_q) begin
						moving_d = 1'b1;
						dir_d    = 1'b0;
						step_d   = '0;
						started  = wtsc_pkg::START_FORWARD;
					end
				end else if (bright) begin
					if (!pos_q) begin
						moving_d = 1'b1;
						dir_d    = 1'b1;
						step_d   = '0;
						started  = wtsc_pkg::START_REVERSE;
					end
				end
				if (edit_d) begin
					unique case (cmd_s1.key_code)
						wtsc_pkg::KEY_TEMP_UP:
							if (temp_lim_q < wtsc_pkg::LimMax) temp_lim_d = temp_lim_q + 7'd1;
						wtsc_pkg::KEY_TEMP_DN:
							if (temp_lim_q != 7'd0) temp_lim_d = temp_lim_q - 7'd1;
						wtsc_pkg::KEY_SMOKE_UP:
							if (smoke_lim_q < wtsc_pkg::LimMax) smoke_lim_d = smoke_lim_q + 7'd1;
						wtsc_pkg::KEY_SMOKE_DN:
							if (smoke_lim_q != 7'd0) smoke_lim_d = smoke_lim_q - 7'd1;
						wtsc_pkg::KEY_HUMID_UP:
							if (humid_lim_q < wtsc_pkg::LimMax) humid_lim_d = humid_lim_q + 7'd1;
						wtsc_pkg::KEY_HUMID_DN:
							if (humid_lim_q != 7'd0) humid_lim_d = humid_lim_q - 7'd1;
						wtsc_pkg::KEY_LIGHT_UP:
							if (light_lim_q != wtsc_pkg::LightMax) light_lim_d = light_lim_q + 8'd1;
						wtsc_pkg::KEY_LIGHT_DN:
							if (light_lim_q != 8'd0) light_lim_d = light_lim_q - 8'd1;
						default: ;
					endcase
				end
			end
		end else if (moving_q) begin
			coils_d = step_q[0] ? (coils_q & ~mask) : (coils_q | mask);
			if (last_step) begin
				moving_d = 1'b0;
				step_d   = '0;
				pos_d    = dir_q;
			end else begin
				step_d = step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edit_q      <= 1'b0;
			pos_q       <= 1'b1;
			smoke_lim_q <= wtsc_pkg::SmokeLimitRst;
			light_lim_q <= wtsc_pkg::LightLimitRst;
			temp_lim_q  <= wtsc_pkg::TempLimitRst;
			humid_lim_q <= wtsc_pkg::HumidityLimitRst;
			coils_q     <= 4'hF;
			moving_q    <= 1'b0;
			dir_q       <= 1'b0;
			step_q      <= '0;
		end else if (adv) begin
			edit_q      <= edit_d;
			pos_q       <= pos_d;
			smoke_lim_q <= smoke_lim_d;
			light_lim_q <= light_lim_d;
			temp_lim_q  <= temp_lim_d;
			humid_lim_q <= humid_lim_d;
			coils_q     <= coils_d;
			moving_q    <= moving_d;
			dir_q       <= dir_d;
			step_q      <= step_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (out_load) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res.coils          <= coils_d;
			res.busy_res       <= moving_d;
			res.position_flag  <= pos_d;
			res.edit_mode      <= edit_d;
			res.smoke_scaled   <= scaled;
			res.move_started   <= started;
			res.limit_smoke    <= smoke_lim_d;
			res.limit_light    <= light_lim_d;
			res.limit_temp     <= temp_lim_d;
			res.limit_humidity <= humid_lim_d;
		end
	end

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> step_q <= wtsc_pkg::StepW'(wtsc_pkg::TotalSteps - 1))
		else $error("step counter beyond the end of a move");

	a_move_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(moving_q) |-> step_q == '0)
		else $error("move started with a nonzero step counter");

	a_control_ignored_while_moving: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd_s1.func == wtsc_pkg::FUNC_CONTROL && moving_q)
		|=> $stable(edit_q) && $stable(smoke_lim_q) && $stable(light_lim_q)
			&& $stable(temp_lim_q) && $stable(humid_lim_q) && moving_q)
		else $error("control beat changed state during a move");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_valid && !res_ready) |-> !cmd_ready)
		else $error("input accepted while both stages are full");

endmodule

`default_nettype wire
